// ===== hdl/eswh_pkg.sv =====
// shared types and constants for the energy and space weighted histogram
package eswh_pkg;

    localparam int IDX_W = 8;
    localparam int OUT_IDX_W = 4;
    localparam int SUM_W = 48;
    localparam int WEIGHT_W = 32;
    localparam int RADDR_W = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int LE_W = 24;
    localparam int BW_W = 23;
    localparam int POS_W = 32;
    localparam int SP_W = 31;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LOG_ENERGY_MIN = 3'd0,
        CFG_LOG_BIN_WIDTH  = 3'd1,
        CFG_ORIGIN_X       = 3'd2,
        CFG_ORIGIN_Y       = 3'd3,
        CFG_ORIGIN_Z       = 3'd4,
        CFG_SPACING_X      = 3'd5,
        CFG_SPACING_Y      = 3'd6,
        CFG_SPACING_Z      = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_HOLD
    } front_state_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_RD
    } back_state_t;

    typedef struct packed {
        logic                is_read;
        logic                ok;
        logic [IDX_W-1:0]    ebin;
        logic [IDX_W-1:0]    cx;
        logic [IDX_W-1:0]    cy;
        logic [IDX_W-1:0]    cz;
        logic [WEIGHT_W-1:0] weight;
        logic [RADDR_W-1:0]  raddr;
    } op_t;

    typedef struct packed {
        logic                 accepted;
        logic [OUT_IDX_W-1:0] energy_bin;
        logic [OUT_IDX_W-1:0] cell_x;
        logic [OUT_IDX_W-1:0] cell_y;
        logic [OUT_IDX_W-1:0] cell_z;
        logic [SUM_W-1:0]     read_value;
    } res_t;

endpackage

// ===== hdl/energy_space_weighted_histogram.sv =====
// top level of the energy and space weighted histogram
// the front end holds one item at a time, full high until its op enters the queue; its
// one-bit-per-cycle divider lanes give QB bits (QB = clog2 of the largest bin or grid
// count, 4 at default sizes); the back end pops an op in B_IDLE, reading the sum memory,
// and writes the sum back in B_RD; an op passes the divider lanes, the two entry queue
// and the op register to the result register; after reset the sum memory is cleared at
// all ENERGY_BINS*GRID_X*GRID_Y*GRID_Z addresses, full held high; config writes taken throughout
module energy_space_weighted_histogram #(
    parameter int ENERGY_BINS = 16,
    parameter int GRID_X      = 16,
    parameter int GRID_Y      = 16,
    parameter int GRID_Z      = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic                                   cmd,
    input  logic signed [eswh_pkg::LE_W-1:0]       log_energy,
    input  logic signed [eswh_pkg::POS_W-1:0]      pos_x,
    input  logic signed [eswh_pkg::POS_W-1:0]      pos_y,
    input  logic signed [eswh_pkg::POS_W-1:0]      pos_z,
    input  logic [eswh_pkg::WEIGHT_W-1:0]          weight,
    input  logic [eswh_pkg::RADDR_W-1:0]           read_address,
    output logic                                   empty,
    input  logic                                   pop,
    output logic                                   accepted,
    output logic [eswh_pkg::OUT_IDX_W-1:0]         energy_bin,
    output logic [eswh_pkg::OUT_IDX_W-1:0]         cell_x,
    output logic [eswh_pkg::OUT_IDX_W-1:0]         cell_y,
    output logic [eswh_pkg::OUT_IDX_W-1:0]         cell_z,
    output logic [eswh_pkg::SUM_W-1:0]             read_value,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [eswh_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [eswh_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int MAXXY = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
    localparam int MAXZE = (GRID_Z > ENERGY_BINS) ? GRID_Z : ENERGY_BINS;
    localparam int MAXN  = (MAXXY > MAXZE) ? MAXXY : MAXZE;
    localparam int QB    = (MAXN > 1) ? $clog2(MAXN) : 1;

    logic signed [eswh_pkg::LE_W-1:0]  le_min_reg;
    logic [eswh_pkg::BW_W-1:0]         bw_reg;
    logic signed [eswh_pkg::POS_W-1:0] ox_reg, oy_reg, oz_reg;
    logic [eswh_pkg::SP_W-1:0]         sx_reg, sy_reg, sz_reg;

    logic           front_busy, clearing, start;
    logic           op_valid, q_full, q_valid, q_pop;
    eswh_pkg::op_t  op, q_data;
    logic           res_valid;
    eswh_pkg::res_t res;

    assign cfg_ready = 1'b1;
    assign full      = front_busy || clearing;
    assign start     = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            le_min_reg <= '0;
            bw_reg     <= eswh_pkg::BW_W'(65536);
            ox_reg     <= '0;
            oy_reg     <= '0;
            oz_reg     <= '0;
            sx_reg     <= eswh_pkg::SP_W'(65536);
            sy_reg     <= eswh_pkg::SP_W'(65536);
            sz_reg     <= eswh_pkg::SP_W'(65536);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (eswh_pkg::cfg_idx_t'(cfg_index))
                eswh_pkg::CFG_LOG_ENERGY_MIN: le_min_reg <= cfg_data[eswh_pkg::LE_W-1:0];
                eswh_pkg::CFG_LOG_BIN_WIDTH:  bw_reg     <= cfg_data[eswh_pkg::BW_W-1:0];
                eswh_pkg::CFG_ORIGIN_X:       ox_reg     <= cfg_data;
                eswh_pkg::CFG_ORIGIN_Y:       oy_reg     <= cfg_data;
                eswh_pkg::CFG_ORIGIN_Z:       oz_reg     <= cfg_data;
                eswh_pkg::CFG_SPACING_X:      sx_reg     <= cfg_data[eswh_pkg::SP_W-1:0];
                eswh_pkg::CFG_SPACING_Y:      sy_reg     <= cfg_data[eswh_pkg::SP_W-1:0];
                eswh_pkg::CFG_SPACING_Z:      sz_reg     <= cfg_data[eswh_pkg::SP_W-1:0];
                default:                      le_min_reg <= le_min_reg;
            endcase
        end
    end

    eswh_front #(
        .ENERGY_BINS (ENERGY_BINS),
        .GRID_X      (GRID_X),
        .GRID_Y      (GRID_Y),
        .GRID_Z      (GRID_Z),
        .QB          (QB)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .cmd            (cmd),
        .log_energy     (log_energy),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .weight         (weight),
        .read_address   (read_address),
        .log_energy_min (le_min_reg),
        .log_bin_width  (bw_reg),
        .origin_x       (ox_reg),
        .origin_y       (oy_reg),
        .origin_z       (oz_reg),
        .spacing_x      (sx_reg),
        .spacing_y      (sy_reg),
        .spacing_z      (sz_reg),
        .busy           (front_busy),
        .op_valid       (op_valid),
        .q_full         (q_full),
        .op             (op)
    );

    eswh_queue #(.W($bits(eswh_pkg::op_t))) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (op_valid),
        .wdata (op),
        .full  (q_full),
        .rd    (q_pop),
        .valid (q_valid),
        .rdata (q_data)
    );

    eswh_back #(
        .ENERGY_BINS (ENERGY_BINS),
        .GRID_X      (GRID_X),
        .GRID_Y      (GRID_Y),
        .GRID_Z      (GRID_Z)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .res_valid (res_valid),
        .res       (res),
        .res_pop   (pop && res_valid)
    );

    assign empty      = !res_valid;
    assign accepted   = res.accepted;
    assign energy_bin = res.energy_bin;
    assign cell_x     = res.cell_x;
    assign cell_y     = res.cell_y;
    assign cell_z     = res.cell_z;
    assign read_value = res.read_value;

endmodule

// ===== hdl/eswh_ram.sv =====
// generic simple dual port ram with registered read
module eswh_ram #(
    parameter int W  = 48,
    parameter int AW = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/eswh_div.sv =====
// restoring divider lane, one quotient bit per step, with range check
module eswh_div #(
    parameter int NW = 32,
    parameter int DW = 31,
    parameter int N  = 16,
    parameter int QB = 4
) (
    input  logic          clk,
    input  logic          start,
    input  logic          step,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QB-1:0] q,
    output logic          ok
);

    localparam int RW = ((NW > DW + QB) ? NW : DW + QB);
    localparam int PW = RW + 1;

    logic [RW-1:0] rem_reg, rem_next;
    logic [RW-1:0] dsh_reg, dsh_next;
    logic [QB-1:0] q_reg, q_next;
    logic          ok_reg, ok_next;
    logic          ge;

    assign ge = (rem_reg >= dsh_reg);

    always_comb
    begin
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        q_next   = q_reg;
        ok_next  = ok_reg;
        if (start)
        begin
            rem_next = RW'(num);
            dsh_next = RW'(den) << (QB - 1);
            q_next   = '0;
            ok_next  = (PW'(num) < (PW'(den) * PW'(N)));
        end
        else if (step)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            dsh_next = dsh_reg >> 1;
            q_next   = QB'({q_reg, ge});
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        ok_reg  <= ok_next;
    end

    assign q  = q_reg;
    assign ok = ok_reg;

endmodule

// ===== hdl/eswh_front.sv =====
// front end: takes items, finds energy bin and cells, hands ops to the queue
module eswh_front #(
    parameter int ENERGY_BINS = 16,
    parameter int GRID_X      = 16,
    parameter int GRID_Y      = 16,
    parameter int GRID_Z      = 16,
    parameter int QB          = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 cmd,
    input  logic signed [eswh_pkg::LE_W-1:0]     log_energy,
    input  logic signed [eswh_pkg::POS_W-1:0]    pos_x,
    input  logic signed [eswh_pkg::POS_W-1:0]    pos_y,
    input  logic signed [eswh_pkg::POS_W-1:0]    pos_z,
    input  logic [eswh_pkg::WEIGHT_W-1:0]        weight,
    input  logic [eswh_pkg::RADDR_W-1:0]         read_address,
    input  logic signed [eswh_pkg::LE_W-1:0]     log_energy_min,
    input  logic [eswh_pkg::BW_W-1:0]            log_bin_width,
    input  logic signed [eswh_pkg::POS_W-1:0]    origin_x,
    input  logic signed [eswh_pkg::POS_W-1:0]    origin_y,
    input  logic signed [eswh_pkg::POS_W-1:0]    origin_z,
    input  logic [eswh_pkg::SP_W-1:0]            spacing_x,
    input  logic [eswh_pkg::SP_W-1:0]            spacing_y,
    input  logic [eswh_pkg::SP_W-1:0]            spacing_z,
    output logic                                 busy,
    output logic                                 op_valid,
    input  logic                                 q_full,
    output eswh_pkg::op_t                        op
);

    localparam int CW = $clog2(QB + 1);
    localparam int EW = eswh_pkg::LE_W + 3;
    localparam int DW33 = eswh_pkg::POS_W + 1;

    eswh_pkg::front_state_t state_reg, state_next;
    logic [CW-1:0]                   cnt_reg, cnt_next;
    logic                            cmd_reg;
    logic [eswh_pkg::WEIGHT_W-1:0]   w_reg;
    logic [eswh_pkg::RADDR_W-1:0]    ra_reg;
    logic [3:0]                      neg_reg;
    logic                            div_step;

    logic [eswh_pkg::BW_W-1:0]       wid_eff;
    logic [eswh_pkg::SP_W-1:0]       spx_eff, spy_eff, spz_eff;
    logic signed [EW-1:0]            num_e;
    logic signed [DW33-1:0]          dx, dy, dz;
    logic [QB-1:0]                   qe, qx, qy, qz;
    logic                            oke, okx, oky, okz;

    assign wid_eff = (log_bin_width == '0) ? eswh_pkg::BW_W'(1) : log_bin_width;
    assign spx_eff = (spacing_x == '0) ? eswh_pkg::SP_W'(1) : spacing_x;
    assign spy_eff = (spacing_y == '0) ? eswh_pkg::SP_W'(1) : spacing_y;
    assign spz_eff = (spacing_z == '0) ? eswh_pkg::SP_W'(1) : spacing_z;

    assign num_e = ((EW'(log_energy) - EW'(log_energy_min)) <<< 1)
                   + $signed(EW'(wid_eff));
    assign dx = DW33'(pos_x) - DW33'(origin_x);
    assign dy = DW33'(pos_y) - DW33'(origin_y);
    assign dz = DW33'(pos_z) - DW33'(origin_z);

    eswh_div #(.NW(EW - 1), .DW(eswh_pkg::BW_W + 1), .N(ENERGY_BINS), .QB(QB)) u_div_e (
        .clk   (clk),
        .start (start),
        .step  (div_step),
        .num   (num_e[EW-2:0]),
        .den   ({wid_eff, 1'b0}),
        .q     (qe),
        .ok    (oke)
    );

    eswh_div #(.NW(eswh_pkg::POS_W), .DW(eswh_pkg::SP_W), .N(GRID_X), .QB(QB)) u_div_x (
        .clk   (clk),
        .start (start),
        .step  (div_step),
        .num   (dx[eswh_pkg::POS_W-1:0]),
        .den   (spx_eff),
        .q     (qx),
        .ok    (okx)
    );

    eswh_div #(.NW(eswh_pkg::POS_W), .DW(eswh_pkg::SP_W), .N(GRID_Y), .QB(QB)) u_div_y (
        .clk   (clk),
        .start (start),
        .step  (div_step),
        .num   (dy[eswh_pkg::POS_W-1:0]),
        .den   (spy_eff),
        .q     (qy),
        .ok    (oky)
    );

    eswh_div #(.NW(eswh_pkg::POS_W), .DW(eswh_pkg::SP_W), .N(GRID_Z), .QB(QB)) u_div_z (
        .clk   (clk),
        .start (start),
        .step  (div_step),
        .num   (dz[eswh_pkg::POS_W-1:0]),
        .den   (spz_eff),
        .q     (qz),
        .ok    (okz)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            eswh_pkg::F_IDLE:
            begin
                if (start)
                begin
                    state_next = eswh_pkg::F_DIV;
                end
            end
            eswh_pkg::F_DIV:
            begin
                if (cnt_reg == CW'(1))
                begin
                    state_next = eswh_pkg::F_HOLD;
                end
            end
            eswh_pkg::F_HOLD:
            begin
                if (!q_full)
                begin
                    state_next = eswh_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = eswh_pkg::F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        div_step = (state_reg == eswh_pkg::F_DIV);
        op_valid = (state_reg == eswh_pkg::F_HOLD);
        busy     = (state_reg != eswh_pkg::F_IDLE);
        cnt_next = cnt_reg;
        if (start)
        begin
            cnt_next = CW'(QB);
        end
        else if (div_step)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= eswh_pkg::F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cmd_reg <= cmd;
            w_reg   <= weight;
            ra_reg  <= read_address;
            neg_reg <= {num_e[EW-1], dx[DW33-1], dy[DW33-1], dz[DW33-1]};
        end
    end

    always_comb
    begin
        op.is_read = cmd_reg;
        op.ok      = !cmd_reg && (neg_reg == 4'b0000) && oke && okx && oky && okz;
        op.ebin    = eswh_pkg::IDX_W'(qe);
        op.cx      = eswh_pkg::IDX_W'(qx);
        op.cy      = eswh_pkg::IDX_W'(qy);
        op.cz      = eswh_pkg::IDX_W'(qz);
        op.weight  = w_reg;
        op.raddr   = ra_reg;
    end

endmodule

// ===== hdl/eswh_queue.sv =====
// two entry queue between front and back
module eswh_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         rd,
    output logic         valid,
    output logic [W-1:0] rdata
);

    logic [W-1:0] ent_reg [2];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;
    logic         do_wr, do_rd;

    assign full  = (cnt_reg == 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign rdata = ent_reg[rp_reg];
    assign do_wr = wr && !full;
    assign do_rd = rd && valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= !wp_reg;
            end
            if (do_rd)
            begin
                rp_reg <= !rp_reg;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            ent_reg[wp_reg] <= wdata;
        end
    end

endmodule

// ===== hdl/eswh_back.sv =====
// back end: clearing pass, read-modify-write of the sums, result register
module eswh_back #(
    parameter int ENERGY_BINS = 16,
    parameter int GRID_X      = 16,
    parameter int GRID_Y      = 16,
    parameter int GRID_Z      = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  eswh_pkg::op_t  q_data,
    output logic           q_pop,
    output logic           clearing,
    output logic           res_valid,
    output eswh_pkg::res_t res,
    input  logic           res_pop
);

    localparam int LW = 34;
    localparam longint unsigned STORE_DEPTH =
        longint'(ENERGY_BINS) * GRID_X * GRID_Y * GRID_Z;
    localparam int AW = $clog2(STORE_DEPTH);

    eswh_pkg::back_state_t state_reg, state_next;
    logic [AW-1:0]              clr_reg, clr_next;
    eswh_pkg::op_t              op_reg;
    logic [AW-1:0]              addr_reg;
    logic                       inr_reg;
    logic                       res_valid_reg, res_valid_next;
    eswh_pkg::res_t             res_reg, res_next;

    logic [LW-1:0]              acc_addr, sel_addr;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [eswh_pkg::SUM_W-1:0] ram_wdata, ram_rdata;
    logic [eswh_pkg::SUM_W:0]   sum;
    logic [eswh_pkg::SUM_W-1:0] sat;
    logic                       load;
    logic                       clr_last;

    assign acc_addr = ((LW'(q_data.ebin) * LW'(GRID_X) + LW'(q_data.cx)) * LW'(GRID_Y)
                      + LW'(q_data.cy)) * LW'(GRID_Z) + LW'(q_data.cz);
    assign sel_addr = q_data.is_read ? LW'(q_data.raddr) : acc_addr;
    assign clr_last = (LW'(clr_reg) == LW'(STORE_DEPTH - 1));

    assign sum = (eswh_pkg::SUM_W + 1)'(ram_rdata)
                 + (eswh_pkg::SUM_W + 1)'(op_reg.weight);
    assign sat = sum[eswh_pkg::SUM_W] ? '1 : sum[eswh_pkg::SUM_W-1:0];

    eswh_ram #(.W(eswh_pkg::SUM_W), .AW(AW)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (sel_addr[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            eswh_pkg::B_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = eswh_pkg::B_IDLE;
                end
            end
            eswh_pkg::B_IDLE:
            begin
                if (q_valid && (!res_valid_reg || res_pop))
                begin
                    state_next = eswh_pkg::B_RD;
                end
            end
            eswh_pkg::B_RD:
            begin
                state_next = eswh_pkg::B_IDLE;
            end
            default:
            begin
                state_next = eswh_pkg::B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        clearing  = 1'b0;
        load      = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = sat;
        clr_next  = clr_reg;
        case (state_reg)
            eswh_pkg::B_CLEAR:
            begin
                clearing  = 1'b1;
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + AW'(1);
            end
            eswh_pkg::B_IDLE:
            begin
                q_pop = q_valid && (!res_valid_reg || res_pop);
            end
            eswh_pkg::B_RD:
            begin
                load   = 1'b1;
                ram_we = op_reg.ok;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res_next = res_reg;
        res_valid_next = res_valid_reg;
        if (res_pop)
        begin
            res_valid_next = 1'b0;
        end
        if (load)
        begin
            res_valid_next      = 1'b1;
            res_next.accepted   = op_reg.ok;
            res_next.energy_bin = op_reg.ok ? op_reg.ebin[eswh_pkg::OUT_IDX_W-1:0] : '0;
            res_next.cell_x     = op_reg.ok ? op_reg.cx[eswh_pkg::OUT_IDX_W-1:0] : '0;
            res_next.cell_y     = op_reg.ok ? op_reg.cy[eswh_pkg::OUT_IDX_W-1:0] : '0;
            res_next.cell_z     = op_reg.ok ? op_reg.cz[eswh_pkg::OUT_IDX_W-1:0] : '0;
            res_next.read_value = (op_reg.is_read && inr_reg) ? ram_rdata : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= eswh_pkg::B_CLEAR;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg   <= q_data;
            addr_reg <= sel_addr[AW-1:0];
            inr_reg  <= (sel_addr < LW'(STORE_DEPTH));
        end
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // result slot is always free when a result is produced
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == eswh_pkg::B_RD) |-> (!res_valid_reg || res_pop))
        else $error("result register overwritten");

    // no op leaves the queue during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == eswh_pkg::B_CLEAR) |-> !q_pop)
        else $error("op popped while clearing");

    // store written only by clearing or by an accepted particle
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == eswh_pkg::B_CLEAR) || (state_reg == eswh_pkg::B_RD && op_reg.ok)))
        else $error("unexpected store write");

    // every popped op yields a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> res_valid_next)
        else $error("popped op produced no result");

endmodule
